// ----- rtl/signed_integer_divider_macros.svh -----
// Assertion helpers for the signed divider checks.
// Each expects signals named clk and rst in the scope where it is used.
`ifndef SIGNED_INTEGER_DIVIDER_MACROS_SVH
`define SIGNED_INTEGER_DIVIDER_MACROS_SVH

// Same-cycle implication.
`define SID_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SID_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/sid_pkg.sv -----
package sid_pkg;

  // Control that travels alongside the operands through the pipeline.
  typedef struct packed {
    logic valid;
    logic neg;
    logic dz;
  } sid_ctrl_t;

endpackage

// ----- rtl/sid_stage.sv -----
module sid_stage #(
  parameter int WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  sid_pkg::sid_ctrl_t  ctrl_in,
  input  logic [WIDTH-1:0]    rem_in,
  input  logic [WIDTH-1:0]    qn_in,
  input  logic [WIDTH-1:0]    den_in,
  output sid_pkg::sid_ctrl_t  ctrl_out,
  output logic [WIDTH-1:0]    rem_out,
  output logic [WIDTH-1:0]    qn_out,
  output logic [WIDTH-1:0]    den_out
);
  import sid_pkg::*;

  logic [WIDTH:0] trial;
  logic [WIDTH:0] diff;
  logic           keep;

  // The dividend bits leave the top of qn while quotient bits enter at the bottom.
  assign trial = {rem_in, qn_in[WIDTH-1]};
  assign keep  = trial >= {1'b0, den_in};
  assign diff  = trial - {1'b0, den_in};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_out.valid <= 1'b0;
    end else if (en) begin
      ctrl_out.valid <= ctrl_in.valid;
    end
    if (en) begin
      ctrl_out.neg <= ctrl_in.neg;
      ctrl_out.dz  <= ctrl_in.dz;
      // Without a subtraction the trial value is below the divisor and fits.
      rem_out      <= keep ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
      qn_out       <= {qn_in[WIDTH-2:0], keep};
      den_out      <= den_in;
    end
  end

endmodule

// ----- rtl/signed_integer_divider.sv -----
// Pipelined signed divider, quotient truncated toward zero.
// Throughput: one request per cycle unless a stall on the output holds the pipeline.
// One restoring step per quotient bit, one stage each.
// A stall on the output freezes the whole pipeline and holds the input side off.
// Reset clears the valid bits of all stages; data registers are not reset.
module signed_integer_divider #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [DATA_WIDTH-1:0] dividend,
  input  logic signed [DATA_WIDTH-1:0] divisor,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [DATA_WIDTH-1:0] quotient,
  output logic                         divide_by_zero,
  output logic                         overflowed
);
  import sid_pkg::*;

  localparam logic [DATA_WIDTH-1:0] MaxPos = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  logic                  en;
  logic [DATA_WIDTH-1:0] nmag;
  logic [DATA_WIDTH-1:0] dmag;

  sid_ctrl_t             ctrl [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] rem  [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] qn   [0:DATA_WIDTH];
  logic [DATA_WIDTH-1:0] den  [0:DATA_WIDTH];

  logic [DATA_WIDTH-1:0] qmag;
  logic [DATA_WIDTH-1:0] quotient_next;
  logic                  overflowed_next;

  assign in_stall = out_valid && out_stall;
  assign en       = !in_stall;

  // Full unsigned magnitudes, so the most negative value stays exact.
  assign nmag = dividend[DATA_WIDTH-1] ? (~dividend + 1'b1) : dividend;
  assign dmag = divisor[DATA_WIDTH-1]  ? (~divisor + 1'b1)  : divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl[0].valid <= 1'b0;
    end else if (en) begin
      ctrl[0].valid <= in_valid;
    end
    if (en) begin
      ctrl[0].neg <= dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
      ctrl[0].dz  <= (dmag == '0);
      rem[0]      <= '0;
      qn[0]       <= nmag;
      den[0]      <= dmag;
    end
  end

  for (genvar k = 0; k < DATA_WIDTH; k++) begin : g_step
    sid_stage #(
      .WIDTH(DATA_WIDTH)
    ) u_stage (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .ctrl_in (ctrl[k]),
      .rem_in  (rem[k]),
      .qn_in   (qn[k]),
      .den_in  (den[k]),
      .ctrl_out(ctrl[k+1]),
      .rem_out (rem[k+1]),
      .qn_out  (qn[k+1]),
      .den_out (den[k+1])
    );
  end

  assign qmag = qn[DATA_WIDTH];

  // Apart from a zero divisor, only the most negative value over minus one can set
  // the top magnitude bit with equal signs.
  always_comb begin
    quotient_next   = qmag;
    overflowed_next = 1'b0;
    if (ctrl[DATA_WIDTH].dz) begin
      quotient_next = '0;
    end else if (ctrl[DATA_WIDTH].neg) begin
      quotient_next = ~qmag + 1'b1;
    end else if (qmag[DATA_WIDTH-1]) begin
      quotient_next   = MaxPos;
      overflowed_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ctrl[DATA_WIDTH].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quotient       <= quotient_next;
      divide_by_zero <= ctrl[DATA_WIDTH].dz;
      overflowed     <= overflowed_next;
    end
  end

endmodule

// ----- rtl/sid_checker.sv -----
`include "signed_integer_divider_macros.svh"

module sid_checker #(
  parameter int DATA_WIDTH = 32
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [DATA_WIDTH-1:0] quotient,
  input logic                         divide_by_zero,
  input logic                         overflowed
);

  localparam logic [DATA_WIDTH-1:0] MaxPos = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  // The input side is held off only by a result waiting downstream.
  `SID_ASSERT(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without cause")
  `SID_ASSERT(a_flags_excl, out_valid, !(divide_by_zero && overflowed), "both flags set")
  `SID_ASSERT(a_dz_zero, out_valid && divide_by_zero, quotient == '0, "quotient not zero")
  `SID_ASSERT(a_ov_sat, out_valid && overflowed, quotient == MaxPos, "overflow not saturated")
  `SID_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(quotient), "result moved")

endmodule

bind signed_integer_divider sid_checker #(.DATA_WIDTH(DATA_WIDTH)) u_sid_checker (.*);
